### src/ufdec_pkg.sv
// ufdec_pkg: shared types, constants and helpers for the utf-8 stream decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package ufdec_pkg;

  localparam int unsigned UFDEC_QUEUE_DEPTH = 4;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned COUNT_W = 3;

  // lead byte patterns
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;

  localparam logic [CP_W-1:0] CP_LIMIT = 21'h10FFFF;

  typedef enum logic [2:0] {
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_BAD
  } byte_class_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  // classified word as held in the queue
  typedef struct packed {
    byte_class_t cls;
    logic [6:0]  payload;
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_push_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_stat_t;

  function automatic logic space_flag(input logic [CP_W-1:0] cp);
    logic hit;
    hit = ((cp >= 21'h09) && (cp <= 21'h0D)) ||
          ((cp >= 21'h2000) && (cp <= 21'h200A)) ||
          (cp == 21'h20)   || (cp == 21'h85)   || (cp == 21'hA0) ||
          (cp == 21'h1680) || (cp == 21'h2028) || (cp == 21'h2029) ||
          (cp == 21'h202F) || (cp == 21'h205F) || (cp == 21'h3000);
    return hit;
  endfunction

endpackage

`default_nettype wire

### src/ufdec_intf.sv
// ufdec_intf: valid/ready channel interfaces for raw bytes and decoded results
// no dependencies; field widths are written out as literals
`default_nettype none

interface ufdec_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface ufdec_result_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [2:0]  byte_count;
  logic [1:0]  status;
  logic        is_space;

  modport source (output valid, output code_point, output byte_count,
                  output status, output is_space, input ready);
  modport sink   (input valid, input code_point, input byte_count,
                  input status, input is_space, output ready);
endinterface

`default_nettype wire

### src/utf8_stream_decoder_unit.sv
// utf8_stream_decoder_unit: top level of the byte-serial utf-8 decoder
// depends on ufdec_pkg, ufdec_intf, ufdec_front, ufdec_queue, ufdec_back
`default_nettype none

// Byte-serial UTF-8 decoder. One raw byte enters per word on the stream
// channel; one decoded word leaves on the decoded channel for each completed
// sequence (ASCII byte, last continuation byte) and for each invalid lead byte.
// The block sustains one byte per clock cycle with no bubbles between
// sequences when not stalled. A byte is classified on entry and written into
// a small register queue (QUEUE_DEPTH words, four by default); the decoder
// pops one word per cycle whenever its single output register is empty or
// being drained. When the output side stalls, the queue keeps taking bytes
// until it is full; bytes that do not complete a sequence still drain from
// the queue only while the output register is free to take a result.
// Continuation bytes are not checked for the 10xxxxxx pattern, overlong
// forms and surrogates decode as ok, and code points above 0x10FFFF come out
// with their value and the above-range status.
module utf8_stream_decoder_unit import ufdec_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = UFDEC_QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  ufdec_byte_if.sink     stream,
  ufdec_result_if.source decoded
);

  queue_push_t  push;
  queue_stat_t  qstat;
  queue_entry_t head;
  logic         pop;

  // classify incoming bytes, ready follows queue space only
  ufdec_front u_front (
    .stream (stream),
    .qstat  (qstat),
    .push   (push)
  );

  // decouples byte intake from the result side
  ufdec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  // sequence state, checks and the output register
  ufdec_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .qstat   (qstat),
    .pop     (pop),
    .decoded (decoded)
  );

endmodule

`default_nettype wire

### src/ufdec_front.sv
// ufdec_front: accepts raw bytes and classifies them by lead pattern
// depends on ufdec_pkg and ufdec_byte_if
`default_nettype none

module ufdec_front import ufdec_pkg::*; (
  ufdec_byte_if.sink  stream,
  input  queue_stat_t qstat,
  output queue_push_t push
);

  byte_class_t cls;

  always_comb begin
    if (!stream.in_byte[7]) begin
      cls = CLS_ASCII;
    end else if ((stream.in_byte & LEAD2_MASK) == LEAD2_MARK) begin
      cls = CLS_LEAD2;
    end else if ((stream.in_byte & LEAD3_MASK) == LEAD3_MARK) begin
      cls = CLS_LEAD3;
    end else if ((stream.in_byte & LEAD4_MASK) == LEAD4_MARK) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign stream.ready          = !qstat.full;
  assign push.valid            = stream.valid && !qstat.full;
  assign push.entry.cls        = cls;
  assign push.entry.payload    = stream.in_byte[6:0];

endmodule

`default_nettype wire

### src/ufdec_queue.sv
// ufdec_queue: small register queue between classifier and decoder
// depends on ufdec_pkg
`default_nettype none

module ufdec_queue import ufdec_pkg::*; #(
  parameter int unsigned DEPTH = UFDEC_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  queue_push_t  push,
  input  logic         pop,
  output queue_entry_t head,
  output queue_stat_t  qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  queue_entry_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push.valid && (count != CNT_W'(DEPTH));
  assign do_pop  = pop && (count != '0);

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head            = entries[rd_ptr];
  assign qstat.not_empty = (count != '0);
  assign qstat.full      = (count == CNT_W'(DEPTH));

endmodule

`default_nettype wire

### src/ufdec_back.sv
// ufdec_back: sequence assembly, range and whitespace checks, result register
// depends on ufdec_pkg and ufdec_result_if
`default_nettype none

module ufdec_back import ufdec_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  queue_entry_t   head,
  input  queue_stat_t    qstat,
  output logic           pop,
  ufdec_result_if.source decoded
);

  logic [1:0]         pending;
  logic [1:0]         pending_next;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] total_next;
  logic [CP_W-1:0]    accum;
  logic [CP_W-1:0]    accum_next;

  logic               out_valid;
  logic [CP_W-1:0]    out_cp;
  logic [COUNT_W-1:0] out_count;
  status_t            out_status;
  logic               out_space;

  logic               emit;
  logic [CP_W-1:0]    res_cp;
  logic [COUNT_W-1:0] res_count;
  status_t            res_status;
  logic [CP_W-1:0]    shifted;
  logic [1:0]         pend_dec;

  assign pop      = qstat.not_empty && (!out_valid || decoded.ready);
  assign shifted  = {accum[CP_W-7:0], head.payload[5:0]};
  assign pend_dec = pending - 2'd1;

  always_comb begin
    emit         = 1'b0;
    res_cp       = '0;
    res_count    = COUNT_W'(1);
    res_status   = ST_OK;
    pending_next = pending;
    total_next   = total;
    accum_next   = accum;
    if (pending != 2'd0) begin
      // continuation word, top bits not checked
      pending_next = pend_dec;
      if (pend_dec == 2'd0) begin
        emit       = 1'b1;
        res_cp     = shifted;
        res_count  = total;
        res_status = (shifted > CP_LIMIT) ? ST_RANGE : ST_OK;
        total_next = '0;
        accum_next = '0;
      end else begin
        accum_next = shifted;
      end
    end else begin
      case (head.cls)
        CLS_ASCII: begin
          emit   = 1'b1;
          res_cp = CP_W'(head.payload);
        end
        CLS_LEAD2: begin
          accum_next   = CP_W'(head.payload[4:0]);
          pending_next = 2'd1;
          total_next   = COUNT_W'(2);
        end
        CLS_LEAD3: begin
          accum_next   = CP_W'(head.payload[3:0]);
          pending_next = 2'd2;
          total_next   = COUNT_W'(3);
        end
        CLS_LEAD4: begin
          accum_next   = CP_W'(head.payload[2:0]);
          pending_next = 2'd3;
          total_next   = COUNT_W'(4);
        end
        default: begin
          emit       = 1'b1;
          res_status = ST_BAD_LEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      total     <= '0;
      accum     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        pending <= pending_next;
        total   <= total_next;
        accum   <= accum_next;
      end
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (decoded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_cp     <= res_cp;
      out_count  <= res_count;
      out_status <= res_status;
      out_space  <= (res_status == ST_OK) && space_flag(res_cp);
    end
  end

  assign decoded.valid      = out_valid;
  assign decoded.code_point = out_cp;
  assign decoded.byte_count = out_count;
  assign decoded.status     = out_status;
  assign decoded.is_space   = out_space;

endmodule

`default_nettype wire

### src/ufdec_checker.sv
// ufdec_checker: port-level checks for the utf-8 stream decoder
// depends on ufdec_pkg; bound to utf8_stream_decoder_unit below
`default_nettype none

module ufdec_checker import ufdec_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [20:0] code_point,
  input logic [2:0]  byte_count,
  input logic [1:0]  status,
  input logic        is_space
);

  // stalled word stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("decoded word dropped while stalled");

  // stalled word keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(code_point) && $stable(byte_count) &&
                                $stable(status) && $stable(is_space))
    else $error("decoded payload changed while stalled");

  // sequence length always one to four
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count >= 3'd1) && (byte_count <= 3'd4))
    else $error("byte count out of range");

  // invalid lead gives a zero single-byte result without whitespace
  a_bad_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_BAD_LEAD) |->
      (code_point == '0) && (byte_count == 3'd1) && !is_space)
    else $error("malformed invalid-lead result");

  // range status matches the value, never carries whitespace; status 3 unused
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_BAD_LEAD) |->
      ((status == ST_RANGE) == (code_point > CP_LIMIT)) &&
      (status != ST_RANGE || !is_space) && (status != 2'd3))
    else $error("status disagrees with code point");

endmodule

bind utf8_stream_decoder_unit ufdec_checker u_ufdec_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (decoded.valid),
  .out_ready  (decoded.ready),
  .code_point (decoded.code_point),
  .byte_count (decoded.byte_count),
  .status     (decoded.status),
  .is_space   (decoded.is_space)
);

`default_nettype wire

### verif/tb_utf8_stream_decoder_unit.sv
// tb_utf8_stream_decoder_unit: self-checking testbench for the utf-8 stream decoder
// depends on ufdec_pkg, ufdec_intf and the utf8_stream_decoder_unit rtl
`timescale 1ns / 100ps

module tb_utf8_stream_decoder_unit;
  import ufdec_pkg::*;

  // one decoded word as the predictor expects it
  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] byte_count;
    status_t            status;
    logic               is_space;
  } decoded_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ufdec_byte_if   stream_ch ();
  ufdec_result_if decoded_ch ();

  utf8_stream_decoder_unit dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (stream_ch.sink),
    .decoded (decoded_ch.source)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [7:0]    pending_bytes[$];   // bytes still to be offered
  decoded_word_t expected_words[$];  // decoded words still to arrive
  int unsigned   cycle_count = 0;
  int unsigned   mismatch_count = 0;
  logic          byte_taken = 1'b0;  // a byte was accepted at the last rising edge
  int unsigned   hold_left = 0;      // remaining cycles of a receiver hold-off

  // decoder state as the predictor sees it
  logic [1:0]      cont_left;
  logic [2:0]      seq_len;
  logic [CP_W-1:0] cp_acc;

  // short directed prologue: ascii ends, a control space, stray and high invalid
  // leads, two- and three-byte spaces, an above-range four-byte form, the
  // largest four-byte value, a continuation without the 10 prefix, u+2000
  logic [7:0] directed_bytes [24] = '{
    8'h00, 8'h7F, 8'h09, 8'h80, 8'hFF, 8'hF8,
    8'hC2, 8'h85,
    8'hE3, 8'h80, 8'h80,
    8'hF4, 8'h90, 8'h80, 8'h80,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hC3, 8'h41,
    8'hE2, 8'h80, 8'h80
  };

  // whitespace list plus its neighbors and the range boundary
  logic [CP_W-1:0] special_cps [25] = '{
    21'h09, 21'h0A, 21'h0B, 21'h0C, 21'h0D, 21'h20, 21'h85, 21'hA0,
    21'h1680, 21'h2000, 21'h2005, 21'h200A, 21'h2028, 21'h2029,
    21'h202F, 21'h205F, 21'h3000,
    21'h08, 21'h0E, 21'h1F, 21'h21, 21'h200B, 21'h10FFFF, 21'h110000,
    21'h1FFFFF
  };

  function automatic logic in_space_list(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    if (cp >= 21'h09 && cp <= 21'h0D) hit = 1'b1;
    if (cp >= 21'h2000 && cp <= 21'h200A) hit = 1'b1;
    case (cp)
      21'h20, 21'h85, 21'hA0, 21'h1680, 21'h2028, 21'h2029,
      21'h202F, 21'h205F, 21'h3000: hit = 1'b1;
      default: ;
    endcase
    return hit;
  endfunction

  // advance the predicted decoder by one byte, queue a word if one results
  task automatic predict_byte(input logic [7:0] b);
    decoded_word_t w;
    logic [CP_W-1:0] cp;
    w = '0;
    if (cont_left != 2'd0) begin
      // any byte counts as a continuation here, top bits ignored
      cp = {cp_acc[CP_W-7:0], b[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left == 2'd0) begin
        w.code_point = cp;
        w.byte_count = seq_len;
        w.status     = (cp > CP_LIMIT) ? ST_RANGE : ST_OK;
        w.is_space   = (w.status == ST_OK) && in_space_list(cp);
        expected_words.push_back(w);
        seq_len = 3'd0;
        cp_acc  = '0;
      end else begin
        cp_acc = cp;
      end
    end else if (!b[7]) begin
      w.code_point = {14'd0, b[6:0]};
      w.byte_count = 3'd1;
      w.status     = ST_OK;
      w.is_space   = in_space_list(w.code_point);
      expected_words.push_back(w);
    end else if ((b & LEAD2_MASK) == LEAD2_MARK) begin
      cp_acc = {16'd0, b[4:0]};
      cont_left = 2'd1;
      seq_len = 3'd2;
    end else if ((b & LEAD3_MASK) == LEAD3_MARK) begin
      cp_acc = {17'd0, b[3:0]};
      cont_left = 2'd2;
      seq_len = 3'd3;
    end else if ((b & LEAD4_MASK) == LEAD4_MARK) begin
      cp_acc = {18'd0, b[2:0]};
      cont_left = 2'd3;
      seq_len = 3'd4;
    end else begin
      // stray continuation or 0xf8..0xff as a lead: error word, byte consumed
      w.code_point = '0;
      w.byte_count = 3'd1;
      w.status     = ST_BAD_LEAD;
      w.is_space   = 1'b0;
      expected_words.push_back(w);
    end
  endtask

  // mostly a proper 10xxxxxx byte, sometimes anything at all
  function automatic logic [7:0] cont_byte();
    logic [7:0] b;
    if ($urandom_range(99) < 85) b = {2'b10, 6'($urandom_range(63))};
    else b = 8'($urandom_range(255));
    return b;
  endfunction

  // shortest encoding of a code point
  task automatic queue_code_point(input logic [CP_W-1:0] cp);
    if (cp < 21'h80) begin
      pending_bytes.push_back({1'b0, cp[6:0]});
    end else if (cp < 21'h800) begin
      pending_bytes.push_back({3'b110, cp[10:6]});
      pending_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      pending_bytes.push_back({4'b1110, cp[15:12]});
      pending_bytes.push_back({2'b10, cp[11:6]});
      pending_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      pending_bytes.push_back({5'b11110, cp[20:18]});
      pending_bytes.push_back({2'b10, cp[17:12]});
      pending_bytes.push_back({2'b10, cp[11:6]});
      pending_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  // one random chunk of stream: mostly whole sequences, some noise and cut-offs
  task automatic queue_random_chunk();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 20) begin
      pending_bytes.push_back(8'($urandom_range(127)));
    end else if (pick < 30) begin
      queue_code_point(special_cps[$urandom_range(24)]);
    end else if (pick < 46) begin
      pending_bytes.push_back({3'b110, 5'($urandom_range(31))});
      pending_bytes.push_back(cont_byte());
    end else if (pick < 62) begin
      pending_bytes.push_back({4'b1110, 4'($urandom_range(15))});
      repeat (2) pending_bytes.push_back(cont_byte());
    end else if (pick < 78) begin
      // leads f4..f7 land above range often
      pending_bytes.push_back({5'b11110, 3'($urandom_range(7))});
      repeat (3) pending_bytes.push_back(cont_byte());
    end else if (pick < 86) begin
      if ($urandom_range(1)) pending_bytes.push_back(8'($urandom_range(8'hBF, 8'h80)));
      else pending_bytes.push_back(8'($urandom_range(8'hFF, 8'hF8)));
    end else if (pick < 93) begin
      // cut-off sequence: the next lead is swallowed as a continuation
      n = $urandom_range(2);
      pending_bytes.push_back({4'b1111, 1'b0, 3'($urandom_range(7))});
      repeat (n) pending_bytes.push_back(cont_byte());
    end else begin
      pending_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  // no idling on either side inside this window
  function automatic logic calm_window();
    return (cycle_count >= 600) && (cycle_count < 1000);
  endfunction

  // byte driver: offers the next byte at the falling edge, holds it until taken
  always @(negedge clk) begin
    if (rst) begin
      stream_ch.valid <= 1'b0;
    end else if (!stream_ch.valid || byte_taken) begin
      if (pending_bytes.size() != 0 && (calm_window() || $urandom_range(99) >= 21)) begin
        stream_ch.valid   <= 1'b1;
        stream_ch.in_byte <= pending_bytes.pop_front();
      end else begin
        stream_ch.valid <= 1'b0;
      end
    end
  end

  // receiver ready: random stalls, plus long hold-offs that back the queue up
  always @(negedge clk) begin
    if (rst) begin
      decoded_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      decoded_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cycle_count == 250 || cycle_count == 1300) begin
      decoded_ch.ready <= 1'b0;
      hold_left <= 80;
    end else begin
      decoded_ch.ready <= calm_window() || ($urandom_range(99) >= 21);
    end
  end

  // monitor: predicts on every accepted byte, checks every accepted word
  always @(posedge clk) begin
    decoded_word_t w;
    cycle_count <= cycle_count + 1;
    if (rst) begin
      byte_taken <= 1'b0;
      cont_left = 2'd0;
      seq_len   = 3'd0;
      cp_acc    = '0;
    end else begin
      byte_taken <= stream_ch.valid && stream_ch.ready;
      if (stream_ch.valid && stream_ch.ready) predict_byte(stream_ch.in_byte);
      if (decoded_ch.valid && decoded_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("%0t: unexpected word cp=%h count=%0d status=%0d space=%b",
                     $realtime, decoded_ch.code_point, decoded_ch.byte_count,
                     decoded_ch.status, decoded_ch.is_space);
        end else begin
          w = expected_words.pop_front();
          if (decoded_ch.code_point !== w.code_point ||
              decoded_ch.byte_count !== w.byte_count ||
              decoded_ch.status !== w.status ||
              decoded_ch.is_space !== w.is_space) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("%0t: word mismatch exp cp=%h count=%0d status=%0d space=%b",
                       $realtime, w.code_point, w.byte_count, w.status, w.is_space,
                       " got cp=%h count=%0d status=%0d space=%b",
                       decoded_ch.code_point, decoded_ch.byte_count,
                       decoded_ch.status, decoded_ch.is_space);
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    stream_ch.valid   = 1'b0;
    stream_ch.in_byte = 8'h00;
    decoded_ch.ready  = 1'b0;
    foreach (directed_bytes[i]) pending_bytes.push_back(directed_bytes[i]);
    while (pending_bytes.size() < 1424) queue_random_chunk();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every byte offered and taken, then every word back, then a short drain
    while (pending_bytes.size() != 0 || stream_ch.valid) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #400000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
